/* rtl/core/tbf_pkg.sv */
// Shared types and constants for the temperature biquad filter.
`default_nettype none

package tbf_pkg;

	// Fixed-point formats
	localparam int COEF_FRAC = 14;
	localparam int IN_SHIFT  = 7;
	localparam int GAIN_W    = 32;
	localparam int X_W       = 16;
	localparam int Y_W       = GAIN_W - COEF_FRAC;
	localparam int NUM_GAINS = 5;
	localparam int CFG_IDX_W = 3;

	// Conversion and clamp limits
	localparam logic signed [11:0] KELVIN_OFFSET = 12'sd273;
	localparam logic signed [11:0] CLAMP_HIGH    = 12'sd127;
	localparam logic signed [11:0] CLAMP_LOW     = -12'sd128;

	// Delay line level after restart: 30 C scaled by 2^7
	localparam logic signed [X_W-1:0] RESTART_X = X_W'(30 << IN_SHIFT);
	localparam logic signed [Y_W-1:0] RESTART_Y = Y_W'(30 << IN_SHIFT);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] IDX_GAIN_B0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] IDX_GAIN_B1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] IDX_GAIN_B2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] IDX_GAIN_A1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] IDX_GAIN_A2 = 3'd4;

	// Operation codes
	localparam logic OP_FILTER  = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	typedef logic [GAIN_W-1:0] gain_t;

	typedef struct packed {
		gain_t b0;
		gain_t b1;
		gain_t b2;
		gain_t a1;
		gain_t a2;
	} gain_bank_t;

	typedef struct packed {
		logic advance;
		logic restart;
	} step_t;

endpackage

`default_nettype wire

/* rtl/core/temperature_biquad_filter_unit.sv */
// An input beat is held in the input register, then in the result register.
// Throughput: one item per cycle unless the result channel stalls; the delay-line
// recursion closes through one multiply-accumulate pass between those two registers.
// Reset: arst_n clears both valid flags and all gains to zero, and presets the
// four delay states to 30 C scaled (3840).
`default_nettype none

module temperature_biquad_filter_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration
	input  wire logic                                cfg_wr_en,
	input  wire logic [tbf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [tbf_pkg::GAIN_W-1:0]          cfg_data,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                op,
	input  wire logic [9:0]                          temp_kelvin,
	// result channel
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [10:0]                       filtered_celsius,
	output logic signed [11:0]                       filtered_kelvin
);

	tbf_pkg::gain_bank_t gains_q;

	logic                            valid_s1;
	logic                            op_s1;
	logic signed [tbf_pkg::X_W-1:0]  x_s1;

	logic signed [11:0]              celsius_raw;
	logic signed [7:0]               celsius_clamped;
	logic signed [tbf_pkg::X_W-1:0]  x_in;

	tbf_pkg::step_t                  step;
	logic signed [tbf_pkg::Y_W-1:0]  y_next;
	logic signed [10:0]              celsius_next;
	logic                            advance;

	// Gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				tbf_pkg::IDX_GAIN_B0: gains_q.b0 <= cfg_data;
				tbf_pkg::IDX_GAIN_B1: gains_q.b1 <= cfg_data;
				tbf_pkg::IDX_GAIN_B2: gains_q.b2 <= cfg_data;
				tbf_pkg::IDX_GAIN_A1: gains_q.a1 <= cfg_data;
				tbf_pkg::IDX_GAIN_A2: gains_q.a2 <= cfg_data;
				default: ;
			endcase
		end
	end

	// Convert to Celsius, clamp to a signed byte and scale by 2^7
	assign celsius_raw = signed'({2'b00, temp_kelvin}) - tbf_pkg::KELVIN_OFFSET;

	always_comb begin
		priority if (celsius_raw > tbf_pkg::CLAMP_HIGH) begin
			celsius_clamped = tbf_pkg::CLAMP_HIGH[7:0];
		end else if (celsius_raw < tbf_pkg::CLAMP_LOW) begin
			celsius_clamped = tbf_pkg::CLAMP_LOW[7:0];
		end else begin
			celsius_clamped = celsius_raw[7:0];
		end
	end

	// Extend the sign into the top bit of the scaled sample
	assign x_in = {celsius_clamped[7], celsius_clamped, {tbf_pkg::IN_SHIFT{1'b0}}};

	// Move the held item on when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= op;
			x_s1  <= x_in;
		end
	end

	assign step = '{advance: advance, restart: (op_s1 == tbf_pkg::OP_RESTART)};

	tbf_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.x      (x_s1),
		.gains  (gains_q),
		.y_next (y_next)
	);

	// Report the new output state in whole Celsius
	assign celsius_next = y_next[tbf_pkg::Y_W-1:tbf_pkg::IN_SHIFT];

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			filtered_celsius <= celsius_next;
			filtered_kelvin  <= 12'(celsius_next) + tbf_pkg::KELVIN_OFFSET;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/tbf_datapath.sv */
// Biquad delay line and Direct Form I multiply-accumulate.
`default_nettype none

module tbf_datapath (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire tbf_pkg::step_t                        step,
	input  wire logic signed [tbf_pkg::X_W-1:0]        x,
	input  wire tbf_pkg::gain_bank_t                   gains,
	output logic signed [tbf_pkg::Y_W-1:0]             y_next
);

	logic signed [tbf_pkg::X_W-1:0] in_d1_q;
	logic signed [tbf_pkg::X_W-1:0] in_d2_q;
	logic signed [tbf_pkg::Y_W-1:0] out_d1_q;
	logic signed [tbf_pkg::Y_W-1:0] out_d2_q;

	logic [tbf_pkg::GAIN_W-1:0] x_ext, in_d1_ext, in_d2_ext, out_d1_ext, out_d2_ext;
	logic [tbf_pkg::GAIN_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
	logic [tbf_pkg::GAIN_W-1:0] acc;

	// Sign-extend samples to the accumulator width
	assign x_ext      = tbf_pkg::GAIN_W'(x);
	assign in_d1_ext  = tbf_pkg::GAIN_W'(in_d1_q);
	assign in_d2_ext  = tbf_pkg::GAIN_W'(in_d2_q);
	assign out_d1_ext = tbf_pkg::GAIN_W'(out_d1_q);
	assign out_d2_ext = tbf_pkg::GAIN_W'(out_d2_q);

	// Five products, each kept modulo 2^32
	assign p_b0 = gains.b0 * x_ext;
	assign p_b1 = gains.b1 * in_d1_ext;
	assign p_b2 = gains.b2 * in_d2_ext;
	assign p_a1 = gains.a1 * out_d1_ext;
	assign p_a2 = gains.a2 * out_d2_ext;

	// Wrapping sum, then drop the Q14 fraction
	assign acc = p_b0 + p_b1 + p_b2 - p_a1 - p_a2;

	always_comb begin
		if (step.restart) begin
			y_next = tbf_pkg::RESTART_Y;
		end else begin
			y_next = signed'(acc[tbf_pkg::GAIN_W-1:tbf_pkg::COEF_FRAC]);
		end
	end

	// Advance or preset the delay line once per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_d1_q  <= tbf_pkg::RESTART_X;
			in_d2_q  <= tbf_pkg::RESTART_X;
			out_d1_q <= tbf_pkg::RESTART_Y;
			out_d2_q <= tbf_pkg::RESTART_Y;
		end else if (step.advance) begin
			if (step.restart) begin
				in_d1_q  <= tbf_pkg::RESTART_X;
				in_d2_q  <= tbf_pkg::RESTART_X;
				out_d1_q <= tbf_pkg::RESTART_Y;
				out_d2_q <= tbf_pkg::RESTART_Y;
			end else begin
				in_d2_q  <= in_d1_q;
				in_d1_q  <= x;
				out_d2_q <= out_d1_q;
				out_d1_q <= y_next;
			end
		end
	end

endmodule

`default_nettype wire

/* tb/sv/biquad_reading_checker.sv */
`timescale 1ns / 1ps
// Checker that predicts and compares the filtered readings of the temperature biquad filter.
module biquad_reading_checker
	import tbf_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [GAIN_W-1:0]    cfg_data,
	input  wire logic                 in_valid,
	input  wire logic                 in_ready,
	input  wire logic                 op,
	input  wire logic [9:0]           temp_kelvin,
	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire logic signed [10:0]   filtered_celsius,
	input  wire logic signed [11:0]   filtered_kelvin,
	output int                        mismatch_count,
	output int                        readings_pending
);

	typedef struct {
		logic signed [10:0] celsius;
		logic signed [11:0] kelvin;
	} reading_t;

	// Shadow copy of the gains and the delay line
	gain_t                   gain_reg [NUM_GAINS];
	logic signed [X_W-1:0]   x_d1;
	logic signed [X_W-1:0]   x_d2;
	logic signed [Y_W-1:0]   y_d1;
	logic signed [Y_W-1:0]   y_d2;
	reading_t                readings_due [$];

	// Advance the delay line by one beat and return the reading it reports
	function automatic reading_t filter_sample(input logic op_code, input logic [9:0] kelvin);
		int                    celsius_in;
		int                    y_report;
		logic signed [X_W-1:0] x_new;
		logic [31:0]           acc;
		logic signed [31:0]    y_full;
		reading_t              r;
		if (op_code == OP_RESTART) begin
			x_d1 = RESTART_X;
			x_d2 = RESTART_X;
			y_d1 = RESTART_Y;
			y_d2 = RESTART_Y;
		end else begin
			// Kelvin to Celsius, clamp to the signed byte range, scale by 2^7
			celsius_in = int'(kelvin) - int'(KELVIN_OFFSET);
			if (celsius_in > int'(CLAMP_HIGH))
				celsius_in = int'(CLAMP_HIGH);
			if (celsius_in < int'(CLAMP_LOW))
				celsius_in = int'(CLAMP_LOW);
			x_new = X_W'(celsius_in * (1 << IN_SHIFT));
			// 32-bit wrapping accumulate, then drop the Q14 fraction
			acc = gain_reg[IDX_GAIN_B0] * 32'(int'(x_new))
				+ gain_reg[IDX_GAIN_B1] * 32'(int'(x_d1))
				+ gain_reg[IDX_GAIN_B2] * 32'(int'(x_d2))
				- gain_reg[IDX_GAIN_A1] * 32'(int'(y_d1))
				- gain_reg[IDX_GAIN_A2] * 32'(int'(y_d2));
			y_full = $signed(acc) >>> COEF_FRAC;
			x_d2 = x_d1;
			y_d2 = y_d1;
			x_d1 = x_new;
			y_d1 = Y_W'(y_full);
		end
		y_report = int'(y_d1) >>> IN_SHIFT;
		r.celsius = 11'(y_report);
		r.kelvin  = 12'(y_report + int'(KELVIN_OFFSET));
		return r;
	endfunction

	// Track config writes, predict on input beats, compare on result beats
	always @(posedge clk or negedge arst_n) begin : watch
		reading_t due;
		int       errs;
		if (!arst_n) begin
			for (int i = 0; i < NUM_GAINS; i++)
				gain_reg[i] = '0;
			x_d1 = RESTART_X;
			x_d2 = RESTART_X;
			y_d1 = RESTART_Y;
			y_d2 = RESTART_Y;
			readings_due.delete();
			readings_pending <= 0;
			mismatch_count   <= 0;
		end else begin
			errs = 0;
			if (cfg_wr_en && cfg_index < NUM_GAINS)
				gain_reg[cfg_index] = cfg_data;
			if (out_valid && out_ready) begin
				if (readings_due.size() == 0) begin
					$error("result beat with no reading expected: celsius %0d, kelvin %0d",
						filtered_celsius, filtered_kelvin);
					errs++;
				end else begin
					due = readings_due.pop_front();
					if (filtered_celsius !== due.celsius) begin
						$error("filtered_celsius mismatch: expected %0d, actual %0d",
							due.celsius, filtered_celsius);
						errs++;
					end
					if (filtered_kelvin !== due.kelvin) begin
						$error("filtered_kelvin mismatch: expected %0d, actual %0d",
							due.kelvin, filtered_kelvin);
						errs++;
					end
				end
			end
			if (in_valid && in_ready)
				readings_due.push_back(filter_sample(op, temp_kelvin));
			readings_pending <= readings_due.size();
			mismatch_count   <= mismatch_count + errs;
		end
	end

endmodule

/* tb/sv/tb_temperature_biquad_filter_unit.sv */
`timescale 1ns / 1ps
// Top-level testbench: stimulus, receiver back-pressure and verdict for the filter unit.
module tb_temperature_biquad_filter_unit;
	import tbf_pkg::*;

	localparam int CLK_HALF_NS     = 10;
	localparam int RESET_CYCLES    = 10;
	localparam int DUT_LATENCY     = 2;
	localparam int RANDOM_BLOCKS   = 10;
	localparam int ITEMS_PER_BLOCK = 95;
	localparam int HOLD_BLOCK      = 6;
	localparam int HOLD_CYCLES     = 200;
	localparam int TIMEOUT_NS      = 5_000_000;

	// Indexes past the last gain; writes there must leave the gains alone
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LAST  = 3'd7;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_wr_en   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = IDX_GAIN_B0;
	logic [GAIN_W-1:0]    cfg_data    = '0;
	logic                 in_valid    = 1'b0;
	logic                 op          = OP_FILTER;
	logic [9:0]           temp_kelvin = '0;
	logic                 out_ready   = 1'b0;
	wire logic            in_ready;
	wire logic            out_valid;
	wire logic signed [10:0] filtered_celsius;
	wire logic signed [11:0] filtered_kelvin;
	int                   mismatch_count;
	int                   readings_pending;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_asks   = 0;
	int hold_seen   = 0;
	int hold_left   = 0;

	temperature_biquad_filter_unit u_dut (.*);

	biquad_reading_checker u_checker (.*);

	always begin
		#CLK_HALF_NS clk = 1'b1;
		#CLK_HALF_NS clk = 1'b0;
	end

	// Receiver: random back-pressure, or a long hold when one is asked for
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asks != hold_seen) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Offer one beat, with an optional idle gap in front, and hold it until taken
	task automatic offer_reading(input logic op_code, input logic [9:0] kelvin);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid    <= 1'b1;
		op          <= op_code;
		temp_kelvin <= kelvin;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and wait until every predicted reading has come back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (readings_pending != 0)
			@(posedge clk);
		repeat (DUT_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input gain_t value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Load a full gain bank, plus a stray write past the last register
	task automatic load_gains(input gain_bank_t bank);
		write_reg(IDX_GAIN_B0, bank.b0);
		write_reg(IDX_GAIN_B1, bank.b1);
		write_reg(IDX_GAIN_B2, bank.b2);
		write_reg(IDX_GAIN_A1, bank.a1);
		write_reg(IDX_GAIN_A2, bank.a2);
		write_reg(CFG_IDX_W'($urandom_range(IDX_SPARE_LAST, IDX_SPARE_FIRST)), $urandom);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic gain_bank_t random_gains();
		gain_t      pick [NUM_GAINS];
		gain_t      tap;
		gain_bank_t bank;
		case ($urandom_range(3))
			0: begin
				for (int i = 0; i < NUM_GAINS; i++)
					pick[i] = gain_t'($urandom_range(65535)) - gain_t'(32768);
			end
			1: begin
				for (int i = 0; i < NUM_GAINS; i++)
					pick[i] = $urandom;
			end
			2: begin
				for (int i = 0; i < NUM_GAINS; i++)
					case ($urandom_range(3))
						0:       pick[i] = 32'h7FFF_FFFF;
						1:       pick[i] = 32'h8000_0000;
						2:       pick[i] = 32'hFFFF_FFFF;
						default: pick[i] = 32'd16384;
					endcase
			end
			default: begin
				// well-behaved low-pass shape
				tap     = gain_t'($urandom_range(2048));
				pick[0] = tap;
				pick[1] = tap << 1;
				pick[2] = tap;
				pick[3] = -gain_t'($urandom_range(28000, 16384));
				pick[4] = gain_t'($urandom_range(12000, 4000));
			end
		endcase
		bank.b0 = pick[0];
		bank.b1 = pick[1];
		bank.b2 = pick[2];
		bank.a1 = pick[3];
		bank.a2 = pick[4];
		return bank;
	endfunction

	// Half over the whole range, half around the clamp band
	function automatic logic [9:0] random_kelvin();
		if ($urandom_range(1))
			return 10'($urandom_range(1023));
		return 10'($urandom_range(420, 120));
	endfunction

	initial begin
		gain_bank_t bank;
		logic [9:0] corner_kelvins [9];
		corner_kelvins = '{10'd0, 10'd144, 10'd145, 10'd273, 10'd400, 10'd401,
			10'd1023, 10'd341, 10'd682};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Gains still at reset: output collapses to zero, restart brings back 30 C
		offer_reading(OP_FILTER, 10'd1023);
		offer_reading(OP_RESTART, 10'd0);
		settle();

		// Unity feedforward: output follows the clamped input
		bank    = '0;
		bank.b0 = 32'd16384;
		load_gains(bank);
		foreach (corner_kelvins[i])
			offer_reading(OP_FILTER, corner_kelvins[i]);
		offer_reading(OP_RESTART, 10'd1023);
		settle();

		// Typical low-pass with feedback
		bank.b0 = 32'd1024;
		bank.b1 = 32'd2048;
		bank.b2 = 32'd1024;
		bank.a1 = -32'd24000;
		bank.a2 = 32'd9000;
		load_gains(bank);
		offer_reading(OP_FILTER, 10'd400);
		offer_reading(OP_FILTER, 10'd400);
		offer_reading(OP_FILTER, 10'd145);
		offer_reading(OP_RESTART, 10'd682);
		settle();

		// Largest positive gains: accumulator wraps
		bank = {NUM_GAINS{32'h7FFF_FFFF}};
		load_gains(bank);
		offer_reading(OP_FILTER, 10'd1023);
		offer_reading(OP_FILTER, 10'd0);
		offer_reading(OP_FILTER, 10'd512);
		settle();

		// Most negative gains
		bank = {NUM_GAINS{32'h8000_0000}};
		load_gains(bank);
		offer_reading(OP_FILTER, 10'd1023);
		offer_reading(OP_FILTER, 10'd0);
		offer_reading(OP_FILTER, 10'd341);
		settle();

		// Random blocks, each with a fresh gain bank and an idle profile set by its block number
		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			if (blk < 3) begin
				tx_idle_pct = 19;
				rx_idle_pct = 50;
			end else if (blk < HOLD_BLOCK) begin
				tx_idle_pct = 50;
				rx_idle_pct = 19;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			load_gains(random_gains());
			for (int i = 0; i < ITEMS_PER_BLOCK; i++) begin
				// stall the receiver for a long stretch while beats keep coming
				if (blk == HOLD_BLOCK && i == 10)
					hold_asks <= hold_asks + 1;
				if ($urandom_range(19) == 0)
					offer_reading(OP_RESTART, 10'($urandom_range(1023)));
				else
					offer_reading(OP_FILTER, random_kelvin());
			end
			settle();
		end

		if (mismatch_count == 0 && readings_pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Give up if the handshakes stop moving
	initial begin
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

endmodule
